[hw/rtl/pol_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the positional ordered list.
// No dependencies; every other file of the block imports this package.
package pol_pkg;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
    logic rd;
    logic fd;
  } cell_cmd_t;

  typedef struct packed {
    logic       rd;
    logic       fd;
    logic [1:0] status;
  } pipe_ctl_t;

endpackage

[hw/rtl/pol_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one key and data word and
// shifts with its neighbors on insert and remove. Uses pol_pkg.
module pol_cell import pol_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int KW  = 32,
  parameter int DW  = 32
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [CW-1:0] pos,
  input  logic [CW-1:0] count,
  input  logic [KW-1:0] new_key,
  input  logic [DW-1:0] new_data,
  input  logic [KW-1:0] prev_key,
  input  logic [DW-1:0] prev_data,
  input  logic [KW-1:0] next_key,
  input  logic [DW-1:0] next_data,
  output logic [KW-1:0] key,
  output logic [DW-1:0] data,
  output logic          hit
);

  localparam logic [CW-1:0] IDX_V = CW'(IDX);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (IDX_V > pos) begin
        key  <= prev_key;
        data <= prev_data;
      end else if (IDX_V == pos) begin
        key  <= new_key;
        data <= new_data;
      end
    end else if (cmd.rem) begin
      if (IDX_V >= pos) begin
        key  <= next_key;
        data <= next_data;
      end
    end else if (cmd.wr && IDX_V == pos) begin
      key  <= new_key;
      data <= new_data;
    end
  end

  assign hit = (cmd.rd && IDX_V == pos) ||
               (cmd.fd && IDX_V < count && key == new_key);

endmodule

[hw/rtl/pol_node.sv]
`timescale 1ns / 1ps
// One registered node of the first-hit selection tree: passes on the left
// child when it hits, otherwise the right child. Uses pol_pkg.
module pol_node import pol_pkg::*; #(
  parameter int IW = 6,
  parameter int KW = 32,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic          l_hit,
  input  logic [IW-1:0] l_pos,
  input  logic [KW-1:0] l_key,
  input  logic [DW-1:0] l_data,
  input  logic          r_hit,
  input  logic [IW-1:0] r_pos,
  input  logic [KW-1:0] r_key,
  input  logic [DW-1:0] r_data,
  output logic          hit,
  output logic [IW-1:0] pos,
  output logic [KW-1:0] key,
  output logic [DW-1:0] data
);

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= l_hit | r_hit;
      if (l_hit) begin
        pos  <= l_pos;
        key  <= l_key;
        data <= l_data;
      end else begin
        pos  <= r_pos;
        key  <= r_key;
        data <= r_data;
      end
    end
  end

endmodule

[hw/rtl/positional_ordered_list.sv]
`timescale 1ns / 1ps
// The result of an accepted transaction is registered in the leaf register and then in each level of the
// registered first-hit tree over the cell chain.
// Throughput: one transaction per cycle; the cell chain shifts, writes and compares in the
// accept cycle, and the tree stalls as a whole when the result is not taken.
// Reset clears the entry count and the pipeline valid bits; cell contents stay undefined.
module positional_ordered_list import pol_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            operation,
  input  logic [CW-1:0]         position,
  input  logic [KEY_WIDTH-1:0]  phone_key,
  input  logic [DATA_WIDTH-1:0] contact_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [KEY_WIDTH-1:0]  read_key,
  output logic [DATA_WIDTH-1:0] read_data,
  output logic                  found,
  output logic [IW-1:0]         found_position,
  output logic [CW-1:0]         entry_count
);

  localparam int P = 1 << IW;
  localparam logic [CW-1:0] DEPTH_V = CW'(DEPTH);

  logic            adv;
  logic            acc;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [1:0]      status_in;
  cell_cmd_t       cmd;
  pipe_ctl_t       ctl [IW+1];
  logic [CW-1:0]   cnt [IW+1];
  logic [IW:0]     vld;

  logic [KEY_WIDTH-1:0]  ck [DEPTH];
  logic [DATA_WIDTH-1:0] cd [DEPTH];
  logic [DEPTH-1:0]      ch;

  logic                  t_hit  [1:2*P-1];
  logic [IW-1:0]         t_pos  [1:2*P-1];
  logic [KEY_WIDTH-1:0]  t_key  [1:2*P-1];
  logic [DATA_WIDTH-1:0] t_data [1:2*P-1];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  always_comb begin
    status_in  = ST_OK;
    count_next = count;
    cmd        = '0;
    cmd.rd     = (operation == OP_READ);
    unique case (operation) inside
      OP_READ, OP_WRITE, OP_REMOVE: begin
        if (count == '0) begin
          status_in = ST_EMPTY;
        end else if (position >= count) begin
          status_in = ST_RANGE;
        end else begin
          cmd.wr  = acc && (operation == OP_WRITE);
          cmd.rem = acc && (operation == OP_REMOVE);
          if (acc && operation == OP_REMOVE) begin
            count_next = count - CW'(1);
          end
        end
      end
      OP_INSERT: begin
        if (position > count) begin
          status_in = ST_RANGE;
        end else if (count == DEPTH_V) begin
          status_in = ST_FULL;
        end else begin
          cmd.ins = acc;
          if (acc) begin
            count_next = count + CW'(1);
          end
        end
      end
      OP_FIND: begin
        cmd.fd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pol_cell #(
      .IDX(i),
      .CW (CW),
      .KW (KEY_WIDTH),
      .DW (DATA_WIDTH)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (position),
      .count    (count),
      .new_key  (phone_key),
      .new_data (contact_data),
      .prev_key ((i > 0) ? ck[(i > 0) ? i - 1 : 0] : phone_key),
      .prev_data((i > 0) ? cd[(i > 0) ? i - 1 : 0] : contact_data),
      .next_key (ck[(i < DEPTH - 1) ? i + 1 : i]),
      .next_data(cd[(i < DEPTH - 1) ? i + 1 : i]),
      .key      (ck[i]),
      .data     (cd[i]),
      .hit      (ch[i])
    );
  end

  for (genvar g = 0; g < P; g++) begin : g_leaf
    assign t_pos[P+g] = IW'(g);
    if (g < DEPTH) begin : g_used
      always_ff @(posedge clk) begin
        if (adv) begin
          t_hit[P+g]  <= ch[g];
          t_key[P+g]  <= ck[g];
          t_data[P+g] <= cd[g];
        end
      end
    end else begin : g_pad
      assign t_hit[P+g]  = 1'b0;
      assign t_key[P+g]  = '0;
      assign t_data[P+g] = '0;
    end
  end

  for (genvar n = 1; n < P; n++) begin : g_node
    pol_node #(
      .IW(IW),
      .KW(KEY_WIDTH),
      .DW(DATA_WIDTH)
    ) u_node (
      .clk   (clk),
      .en    (adv),
      .l_hit (t_hit[2*n]),
      .l_pos (t_pos[2*n]),
      .l_key (t_key[2*n]),
      .l_data(t_data[2*n]),
      .r_hit (t_hit[2*n+1]),
      .r_pos (t_pos[2*n+1]),
      .r_key (t_key[2*n+1]),
      .r_data(t_data[2*n+1]),
      .hit   (t_hit[n]),
      .pos   (t_pos[n]),
      .key   (t_key[n]),
      .data  (t_data[n])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[IW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= '{rd: cmd.rd, fd: cmd.fd, status: status_in};
      cnt[0] <= count_next;
      for (int s = 1; s <= IW; s++) begin
        ctl[s] <= ctl[s-1];
        cnt[s] <= cnt[s-1];
      end
    end
  end

  assign out_valid      = vld[IW];
  assign status         = ctl[IW].status;
  assign read_key       = (ctl[IW].rd && ctl[IW].status == ST_OK) ? t_key[1] : '0;
  assign read_data      = (ctl[IW].rd && ctl[IW].status == ST_OK) ? t_data[1] : '0;
  assign found          = ctl[IW].fd && t_hit[1];
  assign found_position = found ? t_pos[1] : '0;
  assign entry_count    = cnt[IW];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_V)
    else $error("entry count exceeds depth");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    acc && operation == OP_INSERT && count == DEPTH_V |=> count == $past(count))
    else $error("insert into a full list changed the count");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> CW'(found_position) < entry_count)
    else $error("found position outside the list");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> read_key == '0 && read_data == '0 && !found)
    else $error("failed transaction returned data");

endmodule

[test/positional_ordered_list_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for positional_ordered_list: read, write, insert, remove and find
// transactions are checked against a shadow copy of the list kept in the bench.
// Depends on pol_pkg and positional_ordered_list.
module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int DEPTH      = 64;
  localparam int KEY_WIDTH  = 32;
  localparam int DATA_WIDTH = 32;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int IW         = $clog2(DEPTH);
  localparam int LATENCY    = IW + 1;

  localparam logic [2:0]    OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]    OP_UNUSED_LAST  = 3'd7;
  localparam logic [CW-1:0] POS_MAX         = '1;

  typedef struct packed {
    logic [1:0]            status;
    logic [KEY_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0] data;
    logic                  found;
    logic [IW-1:0]         found_pos;
    logic [CW-1:0]         count;
  } list_result_t;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [2:0]            operation    = OP_READ;
  logic [CW-1:0]         position     = '0;
  logic [KEY_WIDTH-1:0]  phone_key    = '0;
  logic [DATA_WIDTH-1:0] contact_data = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [1:0]            status;
  logic [KEY_WIDTH-1:0]  read_key;
  logic [DATA_WIDTH-1:0] read_data;
  logic                  found;
  logic [IW-1:0]         found_position;
  logic [CW-1:0]         entry_count;

  logic [KEY_WIDTH-1:0]  shadow_keys [DEPTH];
  logic [DATA_WIDTH-1:0] shadow_data [DEPTH];
  int                    shadow_count = 0;
  list_result_t          pending_results [$];

  int error_count     = 0;
  int sent_count      = 0;
  int result_count    = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_request    = 0;
  int hold_left       = 0;

  positional_ordered_list #(
    .DEPTH(DEPTH),
    .KEY_WIDTH(KEY_WIDTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .position(position),
    .phone_key(phone_key),
    .contact_data(contact_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .read_key(read_key),
    .read_data(read_data),
    .found(found),
    .found_position(found_position),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic [CW-1:0] pos,
                                                 input logic [KEY_WIDTH-1:0] key,
                                                 input logic [DATA_WIDTH-1:0] dat);
    list_result_t r;
    int p;
    int i;
    r = '0;
    p = int'(pos);
    case (op)
      OP_READ, OP_WRITE, OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= shadow_count) begin
          r.status = ST_RANGE;
        end else if (op == OP_READ) begin
          r.key  = shadow_keys[p];
          r.data = shadow_data[p];
        end else if (op == OP_WRITE) begin
          shadow_keys[p] = key;
          shadow_data[p] = dat;
        end else begin
          for (i = p; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_data[i] = shadow_data[i + 1];
          end
          shadow_count--;
        end
      end
      OP_INSERT: begin
        if (p > shadow_count) begin
          r.status = ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > p; i--) begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_data[i] = shadow_data[i - 1];
          end
          shadow_keys[p] = key;
          shadow_data[p] = dat;
          shadow_count++;
        end
      end
      OP_FIND: begin
        for (i = 0; i < shadow_count && !r.found; i++) begin
          if (shadow_keys[i] == key) begin
            r.found     = 1'b1;
            r.found_pos = IW'(i);
          end
        end
      end
      default: begin
      end
    endcase
    r.count = CW'(shadow_count);
    return r;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < 100) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with no transaction outstanding",
                               result_count));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_error($sformatf("result %0d status %0d, expected %0d",
                                 result_count, status, want.status));
        if (read_key !== want.key)
          report_error($sformatf("result %0d read_key %0h, expected %0h",
                                 result_count, read_key, want.key));
        if (read_data !== want.data)
          report_error($sformatf("result %0d read_data %0h, expected %0h",
                                 result_count, read_data, want.data));
        if (found !== want.found)
          report_error($sformatf("result %0d found %0b, expected %0b",
                                 result_count, found, want.found));
        if (found_position !== want.found_pos)
          report_error($sformatf("result %0d found_position %0d, expected %0d",
                                 result_count, found_position, want.found_pos));
        if (entry_count !== want.count)
          report_error($sformatf("result %0d entry_count %0d, expected %0d",
                                 result_count, entry_count, want.count));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [CW-1:0] pos,
                           input logic [KEY_WIDTH-1:0] key, input logic [DATA_WIDTH-1:0] dat);
    int gap;
    in_valid     <= 1'b1;
    operation    <= op;
    position     <= pos;
    phone_key    <= key;
    contact_data <= dat;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(apply_list_op(op, pos, key, dat));
    sent_count++;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random_items(input int n);
    int roll;
    int ins_share;
    int upper;
    logic [2:0] op;
    logic [CW-1:0] pos;
    logic [KEY_WIDTH-1:0] key;
    repeat (n) begin
      roll      = $urandom_range(99);
      ins_share = (shadow_count < 40) ? 25 : 12;
      if (roll < 5) op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      else if (roll < 20) op = OP_READ;
      else if (roll < 33) op = OP_WRITE;
      else if (roll < 33 + ins_share) op = OP_INSERT;
      else if (roll < 80) op = OP_REMOVE;
      else op = OP_FIND;
      upper = (op == OP_INSERT) ? shadow_count : shadow_count - 1;
      if (upper < 0 || $urandom_range(99) < 15) pos = CW'($urandom_range(POS_MAX));
      else pos = CW'($urandom_range(upper));
      if (op == OP_FIND && shadow_count > 0 && $urandom_range(99) < 60)
        key = shadow_keys[$urandom_range(shadow_count - 1)];
      else if ($urandom_range(99) < 25) key = $urandom_range(7);
      else key = $urandom;
      send_item(op, pos, key, $urandom);
    end
  endtask

  task automatic test_empty_list_and_edges();
    send_item(OP_READ, CW'(0), '0, '0);
    send_item(OP_WRITE, CW'(0), '1, '1);
    send_item(OP_REMOVE, CW'(0), '0, '0);
    send_item(OP_FIND, CW'(0), '0, '0);
    send_item(OP_INSERT, CW'(1), '0, '0);
    send_item(OP_INSERT, CW'(0), '1, '0);
    send_item(OP_INSERT, CW'(0), '0, '1);
    send_item(OP_INSERT, CW'(2), 32'h1234_5678, 32'h8765_4321);
    send_item(OP_READ, CW'(0), '0, '0);
    send_item(OP_READ, CW'(1), '0, '0);
    send_item(OP_READ, CW'(2), '0, '0);
    send_item(OP_READ, CW'(3), '0, '0);
    send_item(OP_READ, POS_MAX, '0, '0);
    send_item(OP_WRITE, CW'(1), 32'h1234_5678, 32'hA5A5_A5A5);
    send_item(OP_FIND, CW'(0), 32'h1234_5678, '0);
    send_item(OP_FIND, CW'(0), '1, '0);
    send_item(OP_FIND, POS_MAX, 32'hDEAD_BEEF, 32'h1234_5678);
    send_item(OP_REMOVE, CW'(3), '0, '0);
    send_item(OP_REMOVE, CW'(0), '0, '0);
    send_item(OP_WRITE, CW'(2), '1, '1);
    send_item(OP_UNUSED_FIRST, CW'(0), '1, '1);
    send_item(OP_UNUSED_LAST, POS_MAX, '1, '1);
    pause_until_drained();
  endtask

  task automatic test_fill_and_drain();
    while (shadow_count < DEPTH)
      send_item(OP_INSERT, CW'($urandom_range(shadow_count)), $urandom, $urandom);
    send_item(OP_INSERT, CW'(DEPTH + 1), '1, '1);
    send_item(OP_INSERT, CW'(DEPTH), '1, '1);
    send_item(OP_INSERT, CW'(0), '1, '1);
    send_item(OP_WRITE, CW'(DEPTH - 1), '1, '0);
    send_item(OP_READ, CW'(DEPTH - 1), '0, '0);
    send_item(OP_FIND, CW'(0), '1, '0);
    send_item(OP_READ, CW'(DEPTH), '0, '0);
    while (shadow_count > 0)
      send_item(OP_REMOVE, CW'($urandom_range(shadow_count - 1)), $urandom, $urandom);
    send_item(OP_REMOVE, CW'(0), '0, '0);
    send_item(OP_FIND, CW'(0), '1, '0);
    pause_until_drained();
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    send_random_items(n);
    pause_until_drained();
  endtask

  task automatic test_output_hold();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 150;
    send_random_items(40);
    pause_until_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_list_and_edges();
    test_fill_and_drain();
    test_random_traffic(280, 0, 0);
    test_random_traffic(280, 59, 0);
    test_output_hold();
    test_random_traffic(280, 0, 59);
    test_random_traffic(280, 12, 12);
    repeat (LATENCY * 3) @(posedge clk);
    $display("Ran %0d transactions and checked %0d results: empty, full and out-of-range cases,",
             sent_count, result_count);
    $display("a %0d-entry fill and drain, key searches, ignored codes and a long output hold.",
             DEPTH);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
